// ----- sv/snc_pkg.sv -----
package snc_pkg;

  localparam int HC_W        = 10;
  localparam int MODE_W      = 2;
  localparam int FRACTION_W  = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int CUT_W       = 10;
  localparam int IDX_W       = 9;
  localparam int NOISE_W     = 24;
  localparam int OUT_FIELD_W = CUT_W + IDX_W + IDX_W + NOISE_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam int FRAC_BITS = 28;
  localparam int Q_W       = 32;
  localparam int TERM_W    = 32;
  localparam int DELTA_W   = TERM_W + 1;
  localparam int SUM_W     = 48;

  localparam logic signed [Q_W:0] W_ONE = 33'sh0_1000_0000;
  localparam logic signed [Q_W:0] W_MIN = 33'sh1_8000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRACTION = 2'd2;

  localparam logic [HC_W-1:0] COUNT_RESET = 10'd512;
  localparam int              COUNT_MIN   = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_JUMP = 2'd0,
    MODE_MIN  = 2'd1,
    MODE_FULL = 2'd2,
    MODE_FRAC = 2'd3
  } cut_mode_t;

  typedef enum logic [2:0] {
    W_IDLE,
    W_SQ,
    W_CHK,
    W_DIV,
    W_ABS,
    W_MUL,
    W_DONE
  } weight_state_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_NRD,
    ST_NACC,
    ST_NDIV,
    ST_NWAIT,
    ST_WRD,
    ST_WGO,
    ST_WWAIT,
    ST_SRD,
    ST_SUPD,
    ST_CUT
  } top_state_t;

  typedef struct packed {
    logic              done;
    logic [TERM_W-1:0] e0;
    logic [TERM_W-1:0] e1;
  } weight_res_t;

endpackage

// ----- sv/spectral_noise_cutoff_select_top.sv -----
// Channel  Dir  Signals                             Payload
// s_*      in   s_tvalid s_tready s_tdata           amplitude
// m_*      out  m_tvalid m_tready m_tdata           cut/min/jump index, noise level
// cfg_*    in   cfg_valid cfg_ready cfg_index/data  harmonic_count, cut_mode, cut_fraction
//
// Amplitudes load one per cycle; the transaction carrying harmonic H-1 starts
// a selection pass: a noise sum over the top quarter of harmonics, a bit-serial
// divide of the AMP_WIDTH+log2(MAX)-bit noise sum, a weight divide per harmonic,
// and a sweep over the harmonics. No input is taken during the pass. Synchronous
// reset, no clearing pass. A result left waiting on m_* stalls only the next pass's end.
module spectral_noise_cutoff_select_top #(
  parameter int MAX_HARMONICS = 512,
  parameter int AMP_WIDTH     = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((AMP_WIDTH+7)/8)*8-1:0]        s_tdata,   // amplitude
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [snc_pkg::OUT_TDATA_W-1:0]       m_tdata,   // cut_index, min_index, jump_index, noise_level
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [snc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [snc_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int IW   = $clog2(MAX_HARMONICS);
  localparam int CW   = $clog2(MAX_HARMONICS + 1);
  localparam int NS_W = AMP_WIDTH + IW;
  localparam int PROD_W = snc_pkg::FRACTION_W + CW;

  snc_pkg::top_state_t state, state_next;

  logic [snc_pkg::HC_W-1:0]       harmonic_count;
  snc_pkg::cut_mode_t             cut_mode;
  logic [snc_pkg::FRACTION_W-1:0] cut_fraction;

  logic [CW-1:0]        h, hl, k;
  logic [IW-1:0]        load_count;
  logic                 accept, last_load, k_last;
  logic [NS_W-1:0]      noise_sum;
  logic [AMP_WIDTH-1:0] noise;
  logic [snc_pkg::SUM_W-1:0]   sum, best_sum, sum_n;
  logic [snc_pkg::DELTA_W-1:0] best_jump, mag;
  logic [IW-1:0]        min_idx, jump_idx;

  logic [AMP_WIDTH-1:0]        amp_store [MAX_HARMONICS];
  logic [AMP_WIDTH-1:0]        amp_q;
  logic signed [snc_pkg::DELTA_W-1:0] delta_store [MAX_HARMONICS];
  logic signed [snc_pkg::DELTA_W-1:0] delta_q, delta_w;
  logic amp_rd, delta_rd, delta_we, div_start, wgt_start, cut_go;

  logic            div_done;
  logic [NS_W-1:0] div_quo;
  snc_pkg::weight_res_t wres;

  logic [PROD_W-1:0] frac_prod;
  logic [CW-1:0]     cut_c;

  logic [snc_pkg::CUT_W-1:0]   out_cut;
  logic [snc_pkg::IDX_W-1:0]   out_min, out_jump;
  logic [snc_pkg::NOISE_W-1:0] out_noise;

  always_comb begin
    if (harmonic_count < snc_pkg::HC_W'(snc_pkg::COUNT_MIN)) begin
      h = CW'(snc_pkg::COUNT_MIN);
    end else if (32'(harmonic_count) > 32'(MAX_HARMONICS)) begin
      h = CW'(MAX_HARMONICS);
    end else begin
      h = CW'(harmonic_count);
    end
  end

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign last_load = !((CW'(load_count) + CW'(1)) < h);
  assign k_last    = (k + CW'(1)) == hl;
  assign delta_w   = signed'({1'b0, wres.e1}) - signed'({1'b0, wres.e0});
  assign sum_n     = sum + {{(snc_pkg::SUM_W-snc_pkg::DELTA_W){delta_q[snc_pkg::DELTA_W-1]}},
                            delta_q};
  assign mag       = delta_q[snc_pkg::DELTA_W-1] ? snc_pkg::DELTA_W'(-delta_q)
                                                 : snc_pkg::DELTA_W'(delta_q);
  assign frac_prod = PROD_W'(cut_fraction) * PROD_W'(hl - CW'(min_idx));

  always_comb begin
    unique case (cut_mode)
      snc_pkg::MODE_JUMP: cut_c = CW'(jump_idx);
      snc_pkg::MODE_MIN:  cut_c = CW'(min_idx);
      snc_pkg::MODE_FULL: cut_c = hl;
      snc_pkg::MODE_FRAC: cut_c = CW'(min_idx) + CW'(frac_prod >> snc_pkg::FRACTION_W);
      default:            cut_c = CW'(min_idx);
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      snc_pkg::ST_LOAD:  if (accept && last_load) state_next = snc_pkg::ST_NRD;
      snc_pkg::ST_NRD:   state_next = snc_pkg::ST_NACC;
      snc_pkg::ST_NACC:  state_next = k_last ? snc_pkg::ST_NDIV : snc_pkg::ST_NRD;
      snc_pkg::ST_NDIV:  state_next = snc_pkg::ST_NWAIT;
      snc_pkg::ST_NWAIT: if (div_done) state_next = snc_pkg::ST_WRD;
      snc_pkg::ST_WRD:   state_next = snc_pkg::ST_WGO;
      snc_pkg::ST_WGO:   state_next = snc_pkg::ST_WWAIT;
      snc_pkg::ST_WWAIT: begin
        if (wres.done) state_next = k_last ? snc_pkg::ST_SRD : snc_pkg::ST_WRD;
      end
      snc_pkg::ST_SRD:   state_next = snc_pkg::ST_SUPD;
      snc_pkg::ST_SUPD:  state_next = k_last ? snc_pkg::ST_CUT : snc_pkg::ST_SRD;
      snc_pkg::ST_CUT:   if (!m_tvalid || m_tready) state_next = snc_pkg::ST_LOAD;
      default:           state_next = snc_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    s_tready  = (state == snc_pkg::ST_LOAD);
    amp_rd    = (state == snc_pkg::ST_NRD) || (state == snc_pkg::ST_WRD);
    div_start = (state == snc_pkg::ST_NDIV);
    wgt_start = (state == snc_pkg::ST_WGO);
    delta_we  = (state == snc_pkg::ST_WWAIT) && wres.done;
    delta_rd  = (state == snc_pkg::ST_SRD);
    cut_go    = (state == snc_pkg::ST_CUT) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (accept) amp_store[load_count] <= s_tdata[AMP_WIDTH-1:0];
    if (amp_rd) amp_q <= amp_store[k[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (delta_we) delta_store[k[IW-1:0]] <= delta_w;
    if (delta_rd) delta_q <= delta_store[k[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= snc_pkg::ST_LOAD;
      harmonic_count <= snc_pkg::COUNT_RESET;
      cut_mode       <= snc_pkg::MODE_MIN;
      cut_fraction   <= '0;
      load_count     <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          snc_pkg::REG_COUNT:    harmonic_count <= cfg_data[snc_pkg::HC_W-1:0];
          snc_pkg::REG_MODE:     cut_mode <= snc_pkg::cut_mode_t'(cfg_data[snc_pkg::MODE_W-1:0]);
          snc_pkg::REG_FRACTION: cut_fraction <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        load_count <= last_load ? '0 : load_count + IW'(1);
      end
      if (cut_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      snc_pkg::ST_LOAD: begin
        if (accept && last_load) begin
          hl        <= h;
          k         <= h - (h >> 2);
          noise_sum <= '0;
        end
      end
      snc_pkg::ST_NACC: begin
        noise_sum <= noise_sum + NS_W'(amp_q);
        k         <= k + CW'(1);
      end
      snc_pkg::ST_NDIV: begin
        k   <= '0;
        sum <= '0;
      end
      snc_pkg::ST_NWAIT: begin
        if (div_done) noise <= div_quo[AMP_WIDTH-1:0];
      end
      snc_pkg::ST_WWAIT: begin
        if (wres.done) begin
          sum <= sum + snc_pkg::SUM_W'(wres.e0);
          if (k_last) begin
            k         <= '0;
            best_sum  <= '1;
            best_jump <= '0;
            min_idx   <= '0;
            jump_idx  <= '0;
          end else begin
            k <= k + CW'(1);
          end
        end
      end
      snc_pkg::ST_SUPD: begin
        sum <= sum_n;
        if (sum_n < best_sum) begin
          best_sum <= sum_n;
          min_idx  <= k[IW-1:0];
        end
        if ((k != '0) && (mag > best_jump)) begin
          best_jump <= mag;
          jump_idx  <= k[IW-1:0];
        end
        k <= k + CW'(1);
      end
      snc_pkg::ST_CUT: begin
        if (cut_go) begin
          out_cut   <= snc_pkg::CUT_W'(cut_c);
          out_min   <= snc_pkg::IDX_W'(min_idx);
          out_jump  <= snc_pkg::IDX_W'(jump_idx);
          out_noise <= snc_pkg::NOISE_W'(noise);
        end
      end
      default: begin
      end
    endcase
  end

  assign m_tdata = {(snc_pkg::OUT_TDATA_W - snc_pkg::OUT_FIELD_W)'(0),
                    out_noise, out_jump, out_min, out_cut};

  snc_noise_div #(
    .NUM_W(NS_W),
    .DEN_W(CW)
  ) u_noise_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (noise_sum),
    .den  (hl >> 2),
    .done (div_done),
    .quo  (div_quo)
  );

  snc_weight #(
    .AMP_WIDTH(AMP_WIDTH)
  ) u_weight (
    .clk  (clk),
    .rst  (rst),
    .start(wgt_start),
    .amp  (amp_q),
    .noise(noise),
    .res  (wres)
  );

endmodule

// ----- sv/snc_noise_div.sv -----
module snc_noise_div #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             active;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] dq;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem, dq[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den};
  assign quo    = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NUM_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= num;
      rem <= '0;
    end else if (active) begin
      rem <= ge ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
      dq  <= {dq[NUM_W-2:0], ge};
    end
  end

endmodule

// ----- sv/snc_weight.sv -----
module snc_weight #(
  parameter int AMP_WIDTH = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [AMP_WIDTH-1:0] amp,
  input  logic [AMP_WIDTH-1:0] noise,
  output snc_pkg::weight_res_t res
);

  localparam int SQ_W  = 2 * AMP_WIDTH;
  localparam int REM_W = SQ_W + 4;
  localparam int CNT_W = $clog2(snc_pkg::Q_W);

  snc_pkg::weight_state_t state, state_next;

  logic [AMP_WIDTH-1:0]        amp_r, noise_r;
  logic [SQ_W-1:0]             a2, n2;
  logic [REM_W-1:0]            rem, d8;
  logic [snc_pkg::Q_W-1:0]     q;
  logic [CNT_W-1:0]            cnt;
  logic                        sat, sat_c;
  logic [snc_pkg::Q_W-1:0]     m0, m1;
  logic [snc_pkg::TERM_W-1:0]  e0, e1;
  logic signed [snc_pkg::Q_W:0] w;
  logic [2*snc_pkg::Q_W-1:0]   p0, p1;

  assign d8    = REM_W'(a2) << 3;
  assign sat_c = REM_W'(n2) >= (d8 + REM_W'(a2));
  assign p0    = (2*snc_pkg::Q_W)'(m0) * (2*snc_pkg::Q_W)'(m0);
  assign p1    = (2*snc_pkg::Q_W)'(m1) * (2*snc_pkg::Q_W)'(m1);

  always_comb begin
    if (sat) begin
      w = snc_pkg::W_MIN;
    end else if (q == '0) begin
      w = snc_pkg::W_ONE - 33'sd1;
    end else begin
      w = snc_pkg::W_ONE - signed'({1'b0, q});
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      snc_pkg::W_IDLE: if (start) state_next = snc_pkg::W_SQ;
      snc_pkg::W_SQ:   state_next = snc_pkg::W_CHK;
      snc_pkg::W_CHK:  state_next = sat_c ? snc_pkg::W_ABS : snc_pkg::W_DIV;
      snc_pkg::W_DIV:  if (cnt == CNT_W'(snc_pkg::Q_W - 1)) state_next = snc_pkg::W_ABS;
      snc_pkg::W_ABS:  state_next = snc_pkg::W_MUL;
      snc_pkg::W_MUL:  state_next = snc_pkg::W_DONE;
      snc_pkg::W_DONE: state_next = snc_pkg::W_IDLE;
      default:         state_next = snc_pkg::W_IDLE;
    endcase
  end

  always_comb begin
    res.done = (state == snc_pkg::W_DONE);
    res.e0   = e0;
    res.e1   = e1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= snc_pkg::W_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      snc_pkg::W_IDLE: begin
        if (start) begin
          amp_r   <= amp;
          noise_r <= noise;
        end
      end
      snc_pkg::W_SQ: begin
        a2 <= SQ_W'(amp_r) * SQ_W'(amp_r);
        n2 <= SQ_W'(noise_r) * SQ_W'(noise_r);
      end
      snc_pkg::W_CHK: begin
        sat <= sat_c;
        rem <= REM_W'(n2);
        q   <= '0;
        cnt <= '0;
      end
      snc_pkg::W_DIV: begin
        if (rem >= d8) begin
          rem <= (rem - d8) << 1;
          q   <= {q[snc_pkg::Q_W-2:0], 1'b1};
        end else begin
          rem <= rem << 1;
          q   <= {q[snc_pkg::Q_W-2:0], 1'b0};
        end
        cnt <= cnt + CNT_W'(1);
      end
      snc_pkg::W_ABS: begin
        m0 <= w[snc_pkg::Q_W] ? snc_pkg::Q_W'(-w) : w[snc_pkg::Q_W-1:0];
        m1 <= snc_pkg::Q_W'(snc_pkg::W_ONE - w);
      end
      snc_pkg::W_MUL: begin
        e0 <= p0[2*snc_pkg::Q_W-1:snc_pkg::Q_W];
        e1 <= p1[2*snc_pkg::Q_W-1:snc_pkg::Q_W];
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- test/snc_checker.sv -----
`timescale 1ns / 100ps
module snc_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [23:0]                      s_tdata,   // amplitude
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [snc_pkg::OUT_TDATA_W-1:0]  m_tdata,   // cut_index, min_index, jump_index, noise_level
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [snc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [snc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                               fails,
  output int                               pending
);

  localparam int MAXH = 512;
  localparam longint signed GAIN_ONE = 64'sd1 << 28;
  localparam longint signed GAIN_MIN = -8 * GAIN_ONE;
  localparam logic [63:0] SUM_MASK = (64'd1 << 48) - 64'd1;

  typedef struct {
    logic [9:0]  cut_index;
    logic [8:0]  min_index;
    logic [8:0]  jump_index;
    logic [23:0] noise_level;
  } cutoff_t;

  cutoff_t cutoff_q[$];
  logic [23:0] amps [0:MAXH-1];
  int unsigned loaded;
  logic [9:0]  hcount;
  logic [1:0]  mode;
  logic [15:0] frac;
  int nfail;

  assign fails   = nfail;
  assign pending = cutoff_q.size();

  function automatic longint signed gain_q28(longint unsigned amp, longint unsigned nz);
    longint unsigned a2, n2, q, rem;
    longint signed g;
    if (amp == 0) return GAIN_MIN;
    a2 = amp * amp;
    n2 = nz * nz;
    q = n2 / a2;
    if (q >= 9) return GAIN_MIN;
    rem = n2 % a2;
    for (int i = 0; i < 28; i++) begin
      q = q << 1;
      if (rem >= a2 - rem) begin
        rem = rem - (a2 - rem);
        q = q | 1;
      end else begin
        rem = rem + rem;
      end
    end
    g = GAIN_ONE - longint'(q);
    if (g > GAIN_ONE - 1) g = GAIN_ONE - 1;
    if (g < GAIN_MIN) g = GAIN_MIN;
    return g;
  endfunction

  function automatic logic [63:0] sq_err(longint signed g, bit brick);
    longint signed d;
    logic [63:0] m;
    d = g - (brick ? GAIN_ONE : 0);
    m = (d < 0) ? -d : d;
    return (m * m) >> 32;
  endfunction

  function automatic int unsigned eff_count(logic [9:0] hc);
    if (hc < snc_pkg::COUNT_MIN) return snc_pkg::COUNT_MIN;
    if (hc > MAXH) return MAXH;
    return 32'(hc);
  endfunction

  task automatic predict_cutoff(input logic [23:0] amp);
    int unsigned h, nq, min_i, jump_i, cut;
    logic [63:0] nsum, noise, sum, prev, best, bjump, diff;
    longint signed g;
    cutoff_t r;
    h = eff_count(hcount);
    amps[loaded % MAXH] = amp;
    if (loaded + 1 < h) begin
      loaded++;
      return;
    end
    loaded = 0;
    nq = h / 4;
    nsum = 0;
    for (int k = h - nq; k < h; k++) nsum += amps[k];
    noise = nsum / nq;
    sum = 0;
    for (int k = 0; k < h; k++) sum += sq_err(gain_q28(amps[k], noise), 0);
    best = SUM_MASK;
    bjump = 0;
    prev = 0;
    min_i = 0;
    jump_i = 0;
    for (int kc = 0; kc < h; kc++) begin
      g = gain_q28(amps[kc], noise);
      sum = (sum - sq_err(g, 0) + sq_err(g, 1)) & SUM_MASK;
      if (sum < best) begin
        best = sum;
        min_i = kc;
      end
      if (kc > 0) begin
        diff = (sum >= prev) ? sum - prev : prev - sum;
        if (diff > bjump) begin
          bjump = diff;
          jump_i = kc;
        end
      end
      prev = sum;
    end
    case (snc_pkg::cut_mode_t'(mode))
      snc_pkg::MODE_JUMP: cut = jump_i;
      snc_pkg::MODE_MIN:  cut = min_i;
      snc_pkg::MODE_FULL: cut = h;
      default:   cut = min_i + int'((longint'(frac) * longint'(h - min_i)) >> 16);
    endcase
    r.cut_index   = cut[9:0];
    r.min_index   = min_i[8:0];
    r.jump_index  = jump_i[8:0];
    r.noise_level = noise[23:0];
    cutoff_q.push_back(r);
  endtask

  always @(posedge clk) begin
    cutoff_t e;
    if (rst) begin
      loaded = 0;
      hcount = snc_pkg::COUNT_RESET;
      mode   = snc_pkg::MODE_MIN;
      frac   = '0;
      nfail  = 0;
      cutoff_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          snc_pkg::REG_COUNT:    hcount = cfg_data[9:0];
          snc_pkg::REG_MODE:     mode   = cfg_data[1:0];
          snc_pkg::REG_FRACTION: frac   = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_cutoff(s_tdata);
      if (m_tvalid && m_tready) begin
        if (cutoff_q.size() == 0) begin
          $error("unexpected result transaction %h", m_tdata);
          nfail++;
        end else begin
          e = cutoff_q.pop_front();
          if (m_tdata[9:0] !== e.cut_index) begin
            $error("cut_index exp %0d got %0d", e.cut_index, m_tdata[9:0]);
            nfail++;
          end
          if (m_tdata[18:10] !== e.min_index) begin
            $error("min_index exp %0d got %0d", e.min_index, m_tdata[18:10]);
            nfail++;
          end
          if (m_tdata[27:19] !== e.jump_index) begin
            $error("jump_index exp %0d got %0d", e.jump_index, m_tdata[27:19]);
            nfail++;
          end
          if (m_tdata[51:28] !== e.noise_level) begin
            $error("noise_level exp %0d got %0d", e.noise_level, m_tdata[51:28]);
            nfail++;
          end
        end
      end
    end
  end
endmodule

// ----- test/tb_spectral_noise_cutoff_select_top.sv -----
`timescale 1ns / 100ps
module tb_spectral_noise_cutoff_select_top;

  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [23:0] s_tdata = 0;  // amplitude
  logic m_tvalid;
  logic m_tready = 0;
  logic [snc_pkg::OUT_TDATA_W-1:0] m_tdata;  // cut_index, min_index, jump_index, noise_level
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [snc_pkg::CFG_IDX_W-1:0] cfg_index = 0;
  logic [snc_pkg::CFG_DATA_W-1:0] cfg_data = 0;

  int fails, pending;
  int sent = 0;
  int results = 0;
  int cycles = 0;
  bit quiet = 0;
  int big_runs = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  spectral_noise_cutoff_select_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  snc_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver; one long hold-off early on so the block backs up
  initial begin
    int gap;
    @(posedge clk iff !rst);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 17);
      if (results == 0) gap = 2000;
      if (gap > 0) begin
        m_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1;
      do @(posedge clk); while (!m_tvalid);
      results++;
    end
  end

  task automatic send_amp(input logic [23:0] amp);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= amp;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic settle();
    s_tvalid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [snc_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  function automatic int unsigned eff_h(int unsigned hc);
    hc = hc & 10'h3FF;
    if (hc < snc_pkg::COUNT_MIN) return snc_pkg::COUNT_MIN;
    if (hc > 512) return 512;
    return hc;
  endfunction

  task automatic send_spectrum(input int unsigned h, input int kind);
    int unsigned sig_end, floor_amp;
    logic [23:0] c;
    sig_end = $urandom_range(1, h);
    floor_amp = $urandom_range(0, 4095);
    c = 24'($urandom);
    for (int k = 0; k < h; k++) begin
      case (kind)
        0: send_amp(k < sig_end ? 24'($urandom_range(floor_amp + 1, 24'hFFFFFF))
                                : 24'($urandom_range(0, floor_amp)));
        1: send_amp(24'($urandom));
        2: send_amp(24'($urandom_range(0, 3)));
        3: send_amp(c);
        default: send_amp(($urandom_range(0, 1) == 1) ? 24'hFFFFFF : 24'h0);
      endcase
    end
  endtask

  initial begin
    int unsigned hc, h;
    int r;
    int spectra;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    cfg_write(snc_pkg::REG_COUNT, 16'd4);
    cfg_write(snc_pkg::REG_MODE, 16'(snc_pkg::MODE_MIN));
    cfg_write(snc_pkg::REG_FRACTION, 16'd0);
    repeat (4) send_amp(24'h0);
    repeat (4) send_amp(24'hFFFFFF);
    send_amp(24'hFFFFFF); send_amp(24'h800000); send_amp(24'h1); send_amp(24'h0);
    settle();
    cfg_write(snc_pkg::REG_MODE, 16'(snc_pkg::MODE_JUMP));
    send_amp(24'd1); send_amp(24'd2); send_amp(24'd3); send_amp(24'd4);
    settle();
    cfg_write(snc_pkg::REG_MODE, 16'(snc_pkg::MODE_FULL));
    send_amp(24'h7FFFFF); send_amp(24'h000100); send_amp(24'h0); send_amp(24'h10);
    settle();
    cfg_write(snc_pkg::REG_MODE, 16'(snc_pkg::MODE_FRAC));
    cfg_write(snc_pkg::REG_FRACTION, 16'hFFFF);
    send_amp(24'hFFFFFF); send_amp(24'hFFFFFF); send_amp(24'h3); send_amp(24'h2);
    settle();
    cfg_write(snc_pkg::REG_FRACTION, 16'h8000);
    send_amp(24'hAAAAAA); send_amp(24'h555555); send_amp(24'h1); send_amp(24'h1);
    settle();

    while (sent < 1600) begin
      r = $urandom_range(0, 99);
      if (r < 3 && big_runs < 2 && sent < 1000) begin
        hc = (big_runs == 0) ? 1023 : 512;
        big_runs++;
        spectra = 1;
      end else begin
        hc = $urandom_range(0, 40);
        spectra = $urandom_range(1, 3);
      end
      h = eff_h(hc);
      quiet = ($urandom_range(0, 4) == 0);
      cfg_write(snc_pkg::REG_COUNT, 16'(hc));
      cfg_write(snc_pkg::REG_MODE, 16'($urandom_range(0, 3)));
      r = $urandom_range(0, 3);
      cfg_write(snc_pkg::REG_FRACTION, r == 0 ? 16'h0 : r == 1 ? 16'hFFFF : 16'($urandom));
      repeat (spectra) begin
        r = $urandom_range(0, 9);
        send_spectrum(h, r < 6 ? 0 : r - 5);
      end
      settle();
    end

    do @(posedge clk); while (pending != 0);
    repeat (200) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
